// ----- rtl/ppu_pkg.sv -----
`timescale 1ns / 1ps

package ppu_pkg;

  localparam logic [1:0] OP_PAL_WR = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_DATA   = 2'd2;

  localparam logic [1:0] DEPTH_1  = 2'd0;
  localparam logic [1:0] DEPTH_4  = 2'd1;
  localparam logic [1:0] DEPTH_8  = 2'd2;
  localparam logic [1:0] DEPTH_16 = 2'd3;

  localparam int JOB_COL_W  = 12;
  localparam int FIFO_DEPTH = 4;

  // is_wr: payload = {index, rgb}; otherwise payload[15:0] = data word
  typedef struct packed {
    logic                 is_wr;
    logic [31:0]          payload;
    logic [2:0]           pos;
    logic [3:0]           cnt;
    logic [JOB_COL_W-1:0] col;
    logic [9:0]           row;
    logic [1:0]           depth;
    logic                 last;
  } job_t;

endpackage

// ----- rtl/palette_pixel_unpacker_unit.sv -----
`timescale 1ns / 1ps

// palette pixel unpacker: packed 1/4/8/16 bpp data in, rgb565 pixel writes out
// in_* stream carries one transaction per item: tuser selects palette entry
//   write, start of a run, or a data word; every transaction is accepted
//   whenever the four-entry job queue has room
// out_* stream gives one transaction per pixel: column, row, rgb565 colour,
//   tlast on the final pixel of the run
// the first pixel of a data word passes through the job queue and the registered
//   output stage; the back end gives one pixel per cycle while the receiver
//   accepts, and a data word gives one pixel at 8 and 16 bpp, up to two at 4
//   bpp and up to eight at 1 bpp; palette writes do not wait on the output stage
// palette reads go through a registered memory port in the pixel pipeline
// reset clears the run state, queue and output stage; palette contents are
//   undefined until written
// a stalled receiver holds the output stage, pixel emission in the back end then
//   stops and the queue fills, after which in_tready drops
module palette_pixel_unpacker_unit #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int COORD_LIMIT     = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // pal_index, pal_rgb, start_col, row, first_offset, pixel_count, depth_mode,
  // data_word, zero pad
  input  logic [87:0] in_tdata,
  // op
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // pixel_col, pixel_row, pixel_color, zero pad
  output logic [39:0] out_tdata,
  output logic        out_tlast
);
  import ppu_pkg::*;

  logic        push_valid, push_ready;
  job_t        push_job;
  logic        q_valid, q_ready;
  job_t        q_job;
  logic [9:0]  pixel_col, pixel_row;
  logic [15:0] pixel_color;

  ppu_front #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES),
    .COORD_LIMIT    (COORD_LIMIT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .op          (in_tuser),
    .pal_index   (in_tdata[7:0]),
    .pal_rgb     (in_tdata[31:8]),
    .start_col   (in_tdata[41:32]),
    .row         (in_tdata[51:42]),
    .first_offset(in_tdata[54:52]),
    .pixel_count (in_tdata[64:55]),
    .depth_mode  (in_tdata[66:65]),
    .data_word   (in_tdata[82:67]),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_job    (push_job)
  );

  ppu_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(push_valid),
    .wr_ready(push_ready),
    .wr_job  (push_job),
    .rd_valid(q_valid),
    .rd_ready(q_ready),
    .rd_job  (q_job)
  );

  ppu_back #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES),
    .COORD_LIMIT    (COORD_LIMIT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_job      (q_job),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .pixel_col  (pixel_col),
    .pixel_row  (pixel_row),
    .pixel_color(pixel_color),
    .run_last   (out_tlast)
  );

  assign out_tdata = {4'd0, pixel_color, pixel_row, pixel_col};

endmodule

// ----- rtl/ppu_front.sv -----
`timescale 1ns / 1ps

module ppu_front #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int COORD_LIMIT     = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [7:0]  pal_index,
  input  logic [23:0] pal_rgb,
  input  logic [9:0]  start_col,
  input  logic [9:0]  row,
  input  logic [2:0]  first_offset,
  input  logic [9:0]  pixel_count,
  input  logic [1:0]  depth_mode,
  input  logic [15:0] data_word,
  output logic        push_valid,
  input  logic        push_ready,
  output ppu_pkg::job_t push_job
);
  import ppu_pkg::*;

  localparam int CW = $clog2(COORD_LIMIT);
  localparam int MW = ((CW > 10) ? CW : 10) + 1;

  logic [CW-1:0] next_col_r, next_col_nxt;
  logic [9:0]    run_row_r, run_row_nxt;
  logic [9:0]    pixels_left_r, pixels_left_nxt;
  logic [2:0]    byte_offset_r, byte_offset_nxt;
  logic [1:0]    run_depth_r, run_depth_nxt;

  logic          accept;
  logic [MW-1:0] start_mod;
  logic [3:0]    avail;
  logic [3:0]    n_pix;
  logic [2:0]    pos;
  logic [CW:0]   col_sum;
  logic [CW:0]   col_adv;

  function automatic logic [MW-1:0] col_wrap(input logic [9:0] c);
    logic [MW-1:0] v;
    v = MW'(c);
    for (int i = 0; i < 4; i++) begin
      if (v >= MW'(COORD_LIMIT)) begin
        v = v - MW'(COORD_LIMIT);
      end
    end
    return v;
  endfunction

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;
  assign start_mod = col_wrap(start_col);

  always_comb begin
    case (run_depth_r)
      DEPTH_1: begin
        pos   = byte_offset_r;
        avail = 4'd8 - {1'b0, byte_offset_r};
      end
      DEPTH_4: begin
        pos   = {2'b00, byte_offset_r[0]};
        avail = byte_offset_r[0] ? 4'd1 : 4'd2;
      end
      default: begin
        pos   = 3'd0;
        avail = 4'd1;
      end
    endcase
    n_pix   = (pixels_left_r < {6'd0, avail}) ? pixels_left_r[3:0] : avail;
    col_sum = {1'b0, next_col_r} + (CW+1)'(n_pix);
    col_adv = (col_sum >= (CW+1)'(COORD_LIMIT)) ? col_sum - (CW+1)'(COORD_LIMIT) : col_sum;
  end

  always_comb begin
    next_col_nxt    = next_col_r;
    run_row_nxt     = run_row_r;
    pixels_left_nxt = pixels_left_r;
    byte_offset_nxt = byte_offset_r;
    run_depth_nxt   = run_depth_r;
    push_valid      = 1'b0;
    push_job        = '0;
    if (accept) begin
      case (op)
        OP_PAL_WR: begin
          push_valid       = ({1'b0, pal_index} < 9'(PALETTE_ENTRIES));
          push_job.is_wr   = 1'b1;
          push_job.payload = {pal_index, pal_rgb};
        end
        OP_START: begin
          next_col_nxt    = CW'(start_mod);
          run_row_nxt     = row;
          byte_offset_nxt = first_offset;
          pixels_left_nxt = pixel_count;
          run_depth_nxt   = depth_mode;
        end
        OP_DATA: begin
          if (pixels_left_r != 10'd0) begin
            push_valid       = 1'b1;
            push_job.payload = {16'd0, data_word};
            push_job.pos     = pos;
            push_job.cnt     = n_pix;
            push_job.col     = JOB_COL_W'(next_col_r);
            push_job.row     = run_row_r;
            push_job.depth   = run_depth_r;
            push_job.last    = (pixels_left_r == 10'(n_pix));
            pixels_left_nxt  = pixels_left_r - 10'(n_pix);
            next_col_nxt     = CW'(col_adv);
            byte_offset_nxt  = 3'd0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_col_r    <= '0;
      run_row_r     <= '0;
      pixels_left_r <= '0;
      byte_offset_r <= '0;
      run_depth_r   <= '0;
    end else begin
      next_col_r    <= next_col_nxt;
      run_row_r     <= run_row_nxt;
      pixels_left_r <= pixels_left_nxt;
      byte_offset_r <= byte_offset_nxt;
      run_depth_r   <= run_depth_nxt;
    end
  end

endmodule

// ----- rtl/ppu_fifo.sv -----
`timescale 1ns / 1ps

module ppu_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  ppu_pkg::job_t wr_job,
  output logic          rd_valid,
  input  logic          rd_ready,
  output ppu_pkg::job_t rd_job
);
  import ppu_pkg::*;

  localparam int AW = $clog2(FIFO_DEPTH);

  job_t          mem_r [FIFO_DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;
  logic          do_wr, do_rd;

  assign wr_ready = (count_r != (AW+1)'(FIFO_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_job   = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (AW+1)'(do_wr) - (AW+1)'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ----- rtl/ppu_back.sv -----
`timescale 1ns / 1ps

module ppu_back #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int COORD_LIMIT     = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_ready,
  input  ppu_pkg::job_t q_job,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [9:0]    pixel_col,
  output logic [9:0]    pixel_row,
  output logic [15:0]   pixel_color,
  output logic          run_last
);
  import ppu_pkg::*;

  localparam int CW = $clog2(COORD_LIMIT);
  localparam int PW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  logic [23:0]   pal_mem [PALETTE_ENTRIES];
  logic [23:0]   rd_data_r;

  logic [2:0]    k_r, k_nxt;
  logic          s1_valid_r, s1_valid_nxt;
  logic          s1_direct_r;
  logic          s1_oor_r;
  logic [15:0]   s1_data_r;
  logic [CW-1:0] s1_col_r;
  logic [9:0]    s1_row_r;
  logic          s1_last_r;

  logic          adv;
  logic          wr_go;
  logic          pix_go;
  logic          job_done;
  logic [3:0]    p;
  logic [7:0]    data_byte;
  logic [7:0]    idx;
  logic          idx_oor;
  logic [CW:0]   col_sum;
  logic [CW-1:0] col_cur;

  function automatic logic [15:0] to_565(input logic [23:0] rgb);
    return {rgb[23:19], rgb[15:10], rgb[7:3]};
  endfunction

  assign adv      = !s1_valid_r || out_ready;
  assign wr_go    = q_valid && q_job.is_wr;
  assign pix_go   = q_valid && !q_job.is_wr && adv;
  assign job_done = ({1'b0, k_r} == (q_job.cnt - 4'd1));
  assign q_ready  = wr_go || (pix_go && job_done);

  always_comb begin
    data_byte = q_job.payload[7:0];
    p         = {1'b0, q_job.pos} + {1'b0, k_r};
    case (q_job.depth)
      DEPTH_1: idx = {7'd0, data_byte[3'(4'd7 - p)]};
      DEPTH_4: idx = (p == 4'd0) ? {4'd0, data_byte[7:4]} : {4'd0, data_byte[3:0]};
      default: idx = data_byte;
    endcase
    idx_oor = ({1'b0, idx} >= 9'(PALETTE_ENTRIES));
    col_sum = {1'b0, q_job.col[CW-1:0]} + (CW+1)'(k_r);
    col_cur = (col_sum >= (CW+1)'(COORD_LIMIT)) ?
              CW'(col_sum - (CW+1)'(COORD_LIMIT)) : CW'(col_sum);
    k_nxt   = k_r;
    if (pix_go) begin
      k_nxt = job_done ? 3'd0 : k_r + 3'd1;
    end
    s1_valid_nxt = adv ? pix_go : s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (wr_go) begin
      pal_mem[q_job.payload[24 +: PW]] <= q_job.payload[23:0];
    end
    if (adv) begin
      rd_data_r <= pal_mem[idx[PW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_direct_r <= (q_job.depth == DEPTH_16);
      s1_oor_r    <= idx_oor;
      s1_data_r   <= q_job.payload[15:0];
      s1_col_r    <= col_cur;
      s1_row_r    <= q_job.row;
      s1_last_r   <= q_job.last && job_done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r        <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      k_r        <= k_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  assign out_valid   = s1_valid_r;
  assign pixel_col   = 10'(s1_col_r);
  assign pixel_row   = s1_row_r;
  assign pixel_color = s1_direct_r ? s1_data_r : (s1_oor_r ? 16'd0 : to_565(rd_data_r));
  assign run_last    = s1_last_r;

endmodule

// ----- tb/palette_pixel_unpacker_unit_test.sv -----
`timescale 1ns / 1ps

module palette_pixel_unpacker_unit_test;
  import ppu_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 4000;
  localparam int TAIL_CYCLES = 16;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  pal_index;
    logic [23:0] pal_rgb;
    logic [9:0]  start_col;
    logic [9:0]  row;
    logic [2:0]  first_offset;
    logic [9:0]  pixel_count;
    logic [1:0]  depth_mode;
    logic [15:0] data_word;
  } item_t;

  typedef struct packed {
    logic [9:0]  col;
    logic [9:0]  row;
    logic [15:0] color;
    logic        last;
  } pixel_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [87:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        out_tlast;

  palette_pixel_unpacker_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  logic [23:0] pal_mem [256];
  logic [9:0]  run_col;
  logic [9:0]  run_row;
  logic [9:0]  run_left;
  logic [2:0]  run_offset;
  logic [1:0]  run_depth;

  pixel_t pending_pixels [$];
  int     mismatch_count = 0;
  int     send_idle_pct  = 0;
  int     recv_idle_pct  = 0;
  int     quiet_cycles   = 0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic logic [15:0] rgb_to_565(input logic [23:0] rgb);
    return {rgb[23:19], rgb[15:10], rgb[7:3]};
  endfunction

  task automatic push_pixel(input logic [15:0] color);
    pixel_t px;
    run_left = run_left - 10'd1;
    px.col   = run_col;
    px.row   = run_row;
    px.color = color;
    px.last  = (run_left == 10'd0);
    pending_pixels.push_back(px);
    run_col = run_col + 10'd1;
  endtask

  task automatic predict_pixels(input item_t it);
    logic [7:0] pbyte;
    int pos;
    pbyte = it.data_word[7:0];
    case (it.op)
      OP_PAL_WR: pal_mem[it.pal_index] = it.pal_rgb;
      OP_START: begin
        run_col    = it.start_col;
        run_row    = it.row;
        run_offset = it.first_offset;
        run_left   = it.pixel_count;
        run_depth  = it.depth_mode;
      end
      OP_DATA: begin
        if (run_left != 10'd0) begin
          case (run_depth)
            DEPTH_1: begin
              for (pos = int'(run_offset); pos < 8 && run_left != 10'd0; pos++)
                push_pixel(rgb_to_565(pal_mem[{7'd0, pbyte[7 - pos]}]));
            end
            DEPTH_4: begin
              if (!run_offset[0]) push_pixel(rgb_to_565(pal_mem[{4'd0, pbyte[7:4]}]));
              if (run_left != 10'd0) push_pixel(rgb_to_565(pal_mem[{4'd0, pbyte[3:0]}]));
            end
            DEPTH_8: push_pixel(rgb_to_565(pal_mem[pbyte]));
            default: push_pixel(it.data_word);
          endcase
          run_offset = 3'd0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.op;
    in_tdata  <= {5'd0, it.data_word, it.depth_mode, it.pixel_count, it.first_offset,
                  it.row, it.start_col, it.pal_rgb, it.pal_index};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_pixels(it);
  endtask

  function automatic item_t random_item(input logic [1:0] op);
    item_t it;
    it.op           = op;
    it.pal_index    = 8'($urandom);
    it.pal_rgb      = 24'($urandom);
    it.start_col    = 10'($urandom);
    it.row          = 10'($urandom);
    it.first_offset = 3'($urandom);
    it.pixel_count  = 10'($urandom);
    it.depth_mode   = 2'($urandom);
    it.data_word    = 16'($urandom);
    // eight bit data stays inside the loaded palette entries
    if (op == OP_DATA && run_depth == DEPTH_8) it.data_word[7:4] = 4'd0;
    return it;
  endfunction

  function automatic item_t start_item(input logic [9:0] col, input logic [9:0] row,
                                       input logic [2:0] offset, input logic [9:0] count,
                                       input logic [1:0] depth);
    item_t it;
    it              = random_item(OP_START);
    it.start_col    = col;
    it.row          = row;
    it.first_offset = offset;
    it.pixel_count  = count;
    it.depth_mode   = depth;
    return it;
  endfunction

  function automatic item_t data_item(input logic [15:0] word);
    item_t it;
    it           = random_item(OP_DATA);
    it.data_word = word;
    return it;
  endfunction

  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic test_palette_load();
    item_t it;
    for (int i = 0; i < 17; i++) begin
      it           = random_item(OP_PAL_WR);
      it.pal_index = (i == 16) ? 8'd255 : 8'(i);
      if (i == 0) it.pal_rgb = 24'h000000;
      if (i == 1) it.pal_rgb = 24'hFFFFFF;
      send_item(it);
    end
  endtask

  task automatic test_edge_cases();
    // stray data, unused op, empty run
    send_item(data_item(16'h00FF));
    send_item(random_item(OP_UNUSED));
    send_item(start_item(10'd5, 10'd7, 3'd0, 10'd0, DEPTH_8));
    send_item(data_item(16'hFFFF));
    // one bit per pixel, offset inside the byte, column wrap
    send_item(start_item(10'd1020, 10'd1023, 3'd5, 10'd10, DEPTH_1));
    send_item(data_item(16'hFFA5));
    send_item(data_item(16'h005A));
    // four bit, odd offset starts at the lower nibble
    send_item(start_item(10'd0, 10'd0, 3'd1, 10'd3, DEPTH_4));
    send_item(data_item(16'hFF3C));
    send_item(data_item(16'h00C3));
    send_item(start_item(10'd100, 10'd1, 3'd6, 10'd3, DEPTH_4));
    send_item(data_item(16'h0012));
    send_item(data_item(16'hABEF));
    // eight bit ignores offset and upper bits
    send_item(start_item(10'd1023, 10'd1023, 3'd7, 10'd2, DEPTH_8));
    send_item(data_item(16'hFF00));
    send_item(data_item(16'h00FF));
    // native pixels pass through
    send_item(start_item(10'd511, 10'd512, 3'd3, 10'd2, DEPTH_16));
    send_item(data_item(16'hFFFF));
    send_item(data_item(16'h0000));
    send_item(data_item(16'h1234));
    // longest run, replaced by a new start partway
    send_item(start_item(10'd0, 10'd0, 3'd0, 10'd1023, DEPTH_1));
    send_item(data_item(16'h0000));
    send_item(data_item(16'h00FF));
    send_item(start_item(10'd8, 10'd9, 3'd0, 10'd1, DEPTH_8));
    send_item(data_item(16'h0001));
  endtask

  task automatic test_random_runs(input int n_items);
    int sent;
    int pick;
    int guard;
    bit broken;
    logic [9:0] count;
    item_t it;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        if ($urandom_range(0, 19) == 0) count = 10'd0;
        else if ($urandom_range(0, 9) == 0) count = 10'($urandom_range(25, 80));
        else count = 10'($urandom_range(1, 24));
        send_item(start_item(10'($urandom), 10'($urandom), 3'($urandom), count,
                             2'($urandom)));
        sent++;
        broken = ($urandom_range(0, 9) == 0);
        guard  = 0;
        while (run_left != 10'd0 && guard < 200) begin
          if (broken && $urandom_range(0, 3) == 0) break;
          send_item(random_item(OP_DATA));
          sent++;
          guard++;
        end
      end else if (pick < 85) begin
        send_item(random_item(OP_PAL_WR));
        sent++;
      end else if (pick < 92) begin
        send_item(random_item(OP_UNUSED));
      end else begin
        it = random_item(OP_DATA);
        send_item(it);
        if (run_left != 10'd0) sent++;
      end
    end
  endtask

  task automatic test_drain_pause();
    send_item(start_item(10'($urandom), 10'($urandom), 3'd0, 10'd16, DEPTH_1));
    send_item(random_item(OP_DATA));
    send_item(random_item(OP_DATA));
    wait_for_drain();
    send_item(start_item(10'($urandom), 10'($urandom), 3'($urandom), 10'd4, DEPTH_4));
    send_item(random_item(OP_DATA));
    send_item(random_item(OP_DATA));
  endtask

  task automatic report_mismatch(input string what, input logic [39:0] expv,
                                 input logic [39:0] gotv);
    $display("mismatch %s: expected %h got %h at %0t", what, expv, gotv, $realtime);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    pixel_t exp_px;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected pixel", 40'd0, out_tdata);
      end else begin
        exp_px = pending_pixels.pop_front();
        if (out_tdata[9:0] !== exp_px.col)
          report_mismatch("pixel_col", 40'(exp_px.col), 40'(out_tdata[9:0]));
        if (out_tdata[19:10] !== exp_px.row)
          report_mismatch("pixel_row", 40'(exp_px.row), 40'(out_tdata[19:10]));
        if (out_tdata[35:20] !== exp_px.color)
          report_mismatch("pixel_color", 40'(exp_px.color), 40'(out_tdata[35:20]));
        if (out_tlast !== exp_px.last)
          report_mismatch("run_last", 40'(exp_px.last), 40'(out_tlast));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tuser   <= OP_PAL_WR;
    in_tdata   <= '0;
    run_col    = '0;
    run_row    = '0;
    run_left   = '0;
    run_offset = '0;
    run_depth  = DEPTH_1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 12;
    recv_idle_pct = 86;
    test_palette_load();
    test_edge_cases();
    test_random_runs(25);

    send_idle_pct = 86;
    recv_idle_pct = 12;
    test_drain_pause();
    test_random_runs(25);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_runs(25);

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/ppu_pkg.sv
rtl/ppu_front.sv
rtl/ppu_fifo.sv
rtl/ppu_back.sv
rtl/palette_pixel_unpacker_unit.sv
tb/palette_pixel_unpacker_unit_test.sv
